// ===== src/rfpwd_pkg.sv =====
package rfpwd_pkg;

  // Field widths
  localparam int unsigned DUR_W   = 16;
  localparam int unsigned TOL_W   = 10;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned RAW_W   = 64;
  localparam int unsigned MAN_W   = 32;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CFG_A_W = 2;
  localparam int unsigned CFG_D_W = 16;
  localparam int unsigned OUT_D_W = 144;

  // Default frame length limit
  localparam int unsigned MAX_BITS_DEF = 128;

  // Configuration register indexes
  localparam logic [CFG_A_W-1:0] REG_ONE_MIN   = 2'd0;
  localparam logic [CFG_A_W-1:0] REG_SPLIT     = 2'd1;
  localparam logic [CFG_A_W-1:0] REG_ZERO_MAX  = 2'd2;
  localparam logic [CFG_A_W-1:0] REG_TOLERANCE = 2'd3;

  // Register reset values
  localparam logic [DUR_W-1:0] ONE_MIN_RST   = 16'd200;
  localparam logic [DUR_W-1:0] SPLIT_RST     = 16'd700;
  localparam logic [DUR_W-1:0] ZERO_MAX_RST  = 16'd1700;
  localparam logic [TOL_W-1:0] TOLERANCE_RST = 10'd100;

  // Frame kinds
  localparam logic [KIND_W-1:0] KIND_NONE    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_24BIT   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_MAN_OK  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_MAN_ERR = 3'd3;
  localparam logic [KIND_W-1:0] KIND_OTHER   = 3'd4;

  // Start sync windows (exclusive bounds)
  localparam logic [DUR_W-1:0] SYNC_A_LO = 16'd13240;
  localparam logic [DUR_W-1:0] SYNC_A_HI = 16'd13350;
  localparam logic [DUR_W-1:0] SYNC_B_LO = 16'd10800;
  localparam logic [DUR_W-1:0] SYNC_B_HI = 16'd11280;
  localparam logic [DUR_W-1:0] SYNC_C_LO = 16'd2800;
  localparam logic [DUR_W-1:0] SYNC_C_HI = 16'd2820;

  // Fixed end sync window (exclusive bounds)
  localparam logic [DUR_W-1:0] END_LO = 16'd10700;
  localparam logic [DUR_W-1:0] END_HI = 16'd10800;

  // Frame lengths with a decoded layout
  localparam int unsigned LEN_24BIT = 24;
  localparam int unsigned LEN_MAN   = 64;

  // One result item
  typedef struct packed {
    logic [KIND_W-1:0]  frame_kind;
    logic [COUNT_W-1:0] bit_count;
    logic [RAW_W-1:0]   raw_code;
    logic [BYTE_W-1:0]  group_byte;
    logic [BYTE_W-1:0]  button_byte;
    logic [BYTE_W-1:0]  switch_state;
    logic [MAN_W-1:0]   manchester_value;
    logic [DUR_W-1:0]   start_sync_us;
  } result_t;

  function automatic logic is_start_sync(input logic [DUR_W-1:0] d);
    is_start_sync = (d > SYNC_A_LO && d < SYNC_A_HI) ||
                    (d > SYNC_B_LO && d < SYNC_B_HI) ||
                    (d > SYNC_C_LO && d < SYNC_C_HI);
  endfunction

endpackage

// ===== src/rf_pulse_width_frame_decoder_unit.sv =====
// Pulse-width frame decoder for on-off-keyed remote controls.
//
// in_*  : one request per measured low-phase duration (us, 0 = timeout).
// out_* : one request per finished or aborted frame: kind in tuser, decoded
//         fields in tdata. Pulses seen while hunting for a start sync, and
//         bits taken into a frame below its limit, give no output.
// cfg_* : write-only register port; the user is to write it only while the
//         block is idle, which the block itself does not enforce.
//
// The input register holds each accepted pulse; classification and frame
// decode write any result into the output register. Throughput is one pulse
// per cycle unless a result waits and out_tready is low.
//
// Reset: hunting, no frame in progress, registers at their defaults, both
// pipeline registers empty.
// Stall: while out_tready is low with a result pending, the pulse in the
// input register waits, and in_tready drops once that register is full.
module rf_pulse_width_frame_decoder_unit #(
  parameter int unsigned MAX_BITS = rfpwd_pkg::MAX_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input stream, tdata: low_us [15:0]
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [rfpwd_pkg::DUR_W-1:0]       in_tdata,
  // Output stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // tdata: bit_count [7:0], raw_code [71:8], group_byte [79:72],
  //        button_byte [87:80], switch_state [95:88],
  //        manchester_value [127:96], start_sync_us [143:128]
  output logic [rfpwd_pkg::OUT_D_W-1:0]     out_tdata,
  // tuser: frame_kind [2:0]
  output logic [rfpwd_pkg::KIND_W-1:0]      out_tuser,
  // Configuration
  input  logic                              cfg_we,
  input  logic [rfpwd_pkg::CFG_A_W-1:0]     cfg_addr,
  input  logic [rfpwd_pkg::CFG_D_W-1:0]     cfg_wdata
);
  import rfpwd_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_BITS + 1);
  localparam int unsigned IDX_W = $clog2(MAN_W);

  // Configuration registers
  logic [DUR_W-1:0] one_min_r, split_r, zero_max_r;
  logic [TOL_W-1:0] tol_r;

  // Input register
  logic             in_valid_r;
  logic [DUR_W-1:0] in_data_r;

  // Frame state
  logic             coll_r, coll_nxt;
  logic [DUR_W-1:0] sync_r, sync_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [RAW_W-1:0] shift_r, shift_nxt;

  // Output register
  logic    out_valid_r, out_valid_nxt;
  result_t res_r, res_nxt;

  // Pipeline control
  logic advance, proc;
  assign advance   = !out_valid_r || out_tready;
  assign proc      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      one_min_r  <= ONE_MIN_RST;
      split_r    <= SPLIT_RST;
      zero_max_r <= ZERO_MAX_RST;
      tol_r      <= TOLERANCE_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_ONE_MIN:   one_min_r  <= cfg_wdata;
        REG_SPLIT:     split_r    <= cfg_wdata;
        REG_ZERO_MAX:  zero_max_r <= cfg_wdata;
        REG_TOLERANCE: tol_r      <= cfg_wdata[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_data_r <= in_tdata;
    end
  end

  // Pulse classification
  logic             is_one, is_zero, is_end;
  logic [CNT_W:0]   count_inc;
  logic [DUR_W:0]   d_plus_tol, sync_plus_tol;
  logic [RAW_W-1:0] shift_bit;

  always_comb begin
    is_one        = in_data_r > one_min_r && in_data_r < split_r;
    is_zero       = in_data_r > split_r && in_data_r < zero_max_r;
    d_plus_tol    = {1'b0, in_data_r} + {{(DUR_W+1-TOL_W){1'b0}}, tol_r};
    sync_plus_tol = {1'b0, sync_r} + {{(DUR_W+1-TOL_W){1'b0}}, tol_r};
    is_end        = (in_data_r > END_LO && in_data_r < END_HI) ||
                    (d_plus_tol > {1'b0, sync_r} && {1'b0, in_data_r} < sync_plus_tol);
    count_inc     = {1'b0, count_r} + {{CNT_W{1'b0}}, 1'b1};
    shift_bit     = {shift_r[RAW_W-2:0], is_one};
  end

  // Frame state update and frame end selection
  logic             emit;
  logic [CNT_W-1:0] emit_n;
  logic [RAW_W-1:0] emit_raw;

  always_comb begin
    coll_nxt  = coll_r;
    sync_nxt  = sync_r;
    count_nxt = count_r;
    shift_nxt = shift_r;
    emit      = 1'b0;
    emit_n    = '0;
    emit_raw  = '0;
    if (proc) begin
      if (!coll_r) begin
        if (is_start_sync(in_data_r)) begin
          coll_nxt  = 1'b1;
          sync_nxt  = in_data_r;
          count_nxt = '0;
          shift_nxt = '0;
        end
      end else if (is_one || is_zero) begin
        if (count_inc >= (CNT_W+1)'(MAX_BITS)) begin
          emit     = 1'b1;
          emit_n   = count_inc[CNT_W-1:0];
          emit_raw = shift_bit;
        end else begin
          count_nxt = count_inc[CNT_W-1:0];
          shift_nxt = shift_bit;
        end
      end else begin
        // end sync keeps the bits, anything else aborts with none
        emit = 1'b1;
        if (is_end) begin
          emit_n   = count_r;
          emit_raw = (count_r == '0) ? '0 : shift_r;
        end
      end
      if (emit) begin
        coll_nxt  = 1'b0;
        count_nxt = '0;
        shift_nxt = '0;
      end
    end
  end

  // Manchester pairs: highest equal pair stops the decode
  logic [MAN_W-1:0] man_a, man_eq;
  logic [IDX_W-1:0] err_idx;
  logic [IDX_W:0]   man_sh;
  logic [MAN_W-1:0] man_val;

  always_comb begin
    err_idx = '0;
    for (int p = 0; p < MAN_W; p++) begin
      man_a[p]  = emit_raw[2*p+1];
      man_eq[p] = emit_raw[2*p+1] == emit_raw[2*p];
      if (man_eq[p]) begin
        err_idx = IDX_W'(p);
      end
    end
    man_sh  = {1'b0, err_idx} + {{IDX_W{1'b0}}, 1'b1};
    man_val = (|man_eq) ? (man_a >> man_sh) : man_a;
  end

  // Result assembly
  always_comb begin
    res_nxt                  = '0;
    res_nxt.bit_count        = COUNT_W'(emit_n);
    res_nxt.raw_code         = emit_raw;
    res_nxt.start_sync_us    = sync_r;
    if (emit_n == CNT_W'(LEN_24BIT)) begin
      res_nxt.frame_kind   = KIND_24BIT;
      res_nxt.group_byte   = emit_raw[23:16];
      res_nxt.button_byte  = emit_raw[15:8];
      res_nxt.switch_state = emit_raw[7:0];
    end else if (emit_n == CNT_W'(LEN_MAN)) begin
      res_nxt.frame_kind       = (|man_eq) ? KIND_MAN_ERR : KIND_MAN_OK;
      res_nxt.manchester_value = man_val;
    end else if (emit_n != '0) begin
      res_nxt.frame_kind = KIND_OTHER;
    end else begin
      res_nxt.frame_kind = KIND_NONE;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (proc && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // State and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coll_r      <= 1'b0;
      sync_r      <= '0;
      count_r     <= '0;
      shift_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      coll_r      <= coll_nxt;
      sync_r      <= sync_nxt;
      count_r     <= count_nxt;
      shift_r     <= shift_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && emit) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.frame_kind;
  assign out_tdata  = {res_r.start_sync_us, res_r.manchester_value, res_r.switch_state,
                       res_r.button_byte, res_r.group_byte, res_r.raw_code,
                       res_r.bit_count};

  // Checks
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid_r && !coll_r)
    else $error("reset left a frame or a result pending");

  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    count_r < CNT_W'(MAX_BITS))
    else $error("bit count reached the frame limit without ending the frame");

  a_hunt_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !coll_r |-> count_r == '0 && shift_r == '0)
    else $error("bits held while hunting for sync");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.frame_kind == KIND_NONE |->
      res_r.bit_count == '0 && res_r.raw_code == '0)
    else $error("empty frame result carries bits");

  a_hunt_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    proc && !coll_r |-> !emit)
    else $error("result raised while hunting for sync");

endmodule
